// File: design/qte_pkg.sv
// shared constants, types and the arctangent table for the quaternion to euler unit
package qte_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int FRAC_BITS  = DATA_WIDTH - 2;
  localparam int TERM_FRAC  = 28;
  localparam int PROD_SHIFT = 2 * FRAC_BITS - TERM_FRAC;
  localparam int PS_RIGHT   = (PROD_SHIFT > 0) ? PROD_SHIFT : 0;
  localparam int PS_LEFT    = (PROD_SHIFT < 0) ? -PROD_SHIFT : 0;

  localparam int TW         = TERM_FRAC + 8;
  localparam int CW         = TW + 2;
  localparam int EW         = TERM_FRAC + 2;
  localparam int SQ_W       = 2 * TERM_FRAC + 1;
  localparam int ROOT_W     = TERM_FRAC + 1;
  localparam int ISQ_STAGES = TERM_FRAC + 1;
  localparam int AW         = 32;
  localparam int ANGLE_W    = 16;

  localparam logic signed [ANGLE_W-1:0] PITCH_MAX = ANGLE_W'(16384);
  localparam logic signed [ANGLE_W-1:0] PITCH_MIN = -ANGLE_W'(16384);

  localparam logic [AW-1:0] ANG_QUARTER  = 32'h4000_0000;
  localparam logic [AW-1:0] ANG_NQUARTER = 32'hC000_0000;
  localparam logic [AW-1:0] ANG_ROUND    = 32'h0000_8000;

  localparam logic [AW-1:0] ATAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic                   valid;
    logic signed [TW-1:0]   hy;
    logic signed [TW-1:0]   hx;
    logic signed [TW-1:0]   ry;
    logic signed [TW-1:0]   rx;
    logic signed [EW-1:0]   e21c;
    logic [SQ_W-1:0]        rad;
  } qte_terms_t;

  function automatic logic signed [TW-1:0] scale_prod(logic signed [2*DATA_WIDTH-1:0] p);
    logic signed [2*DATA_WIDTH-1:0] r;
    logic signed [TW-1:0] t;
    r = p >>> PS_RIGHT;
    t = TW'(r);
    return t <<< PS_LEFT;
  endfunction

endpackage

// File: design/quaternion_to_euler_angles_unit.sv
// top level of the quaternion to z-x-y euler angle unit
// Takes one quaternion beat per cycle whenever start is high; busy stays low, so
// every beat is taken. The pitch passes through the matrix term stages, the
// bit-per-stage square root for the arcsine, the 16-stage cordic and an output
// register, with heading and roll delayed to match; each result is shown for one cycle with done_o and cannot be held.
module quaternion_to_euler_angles_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [qte_pkg::DATA_WIDTH-1:0] quat_w_i,
  input  logic signed [qte_pkg::DATA_WIDTH-1:0] quat_x_i,
  input  logic signed [qte_pkg::DATA_WIDTH-1:0] quat_y_i,
  input  logic signed [qte_pkg::DATA_WIDTH-1:0] quat_z_i,
  output logic                                  done_o,
  output logic signed [qte_pkg::ANGLE_W-1:0]    heading_angle_o,
  output logic signed [qte_pkg::ANGLE_W-1:0]    pitch_angle_o,
  output logic signed [qte_pkg::ANGLE_W-1:0]    roll_angle_o
);

  localparam int ND = qte_pkg::ISQ_STAGES;
  localparam int AN = qte_pkg::ANGLE_W;

  assign busy = 1'b0;

  qte_pkg::qte_terms_t terms;

  qte_terms u_terms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .w_i     (quat_w_i),
    .x_i     (quat_x_i),
    .y_i     (quat_y_i),
    .z_i     (quat_z_i),
    .terms_o (terms)
  );

  logic                              sq_valid;
  logic [qte_pkg::ROOT_W-1:0]        sq_root;
  logic signed [qte_pkg::EW-1:0]     sq_e21c;

  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (terms.valid),
    .rad_i   (terms.rad),
    .tag_i   (terms.e21c),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .tag_o   (sq_e21c)
  );

  logic          p_valid, h_valid, r_valid;
  logic [AN-1:0] p_ang, h_ang, r_ang;

  qte_cordic u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .y_i     (qte_pkg::TW'(sq_e21c)),
    .x_i     ($signed({{(qte_pkg::TW - qte_pkg::ROOT_W){1'b0}}, sq_root})),
    .valid_o (p_valid),
    .angle_o (p_ang)
  );

  qte_cordic u_heading (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (terms.valid),
    .y_i     (terms.hy),
    .x_i     (terms.hx),
    .valid_o (h_valid),
    .angle_o (h_ang)
  );

  qte_cordic u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (terms.valid),
    .y_i     (terms.ry),
    .x_i     (terms.rx),
    .valid_o (r_valid),
    .angle_o (r_ang)
  );

  // align heading and roll with the square root latency
  logic [AN-1:0] hd_q [ND];
  logic [AN-1:0] rd_q [ND];

  for (genvar s = 0; s < ND; s++) begin : g_dly
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        hd_q[s] <= h_ang;
        rd_q[s] <= r_ang;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        hd_q[s] <= hd_q[s-1];
        rd_q[s] <= rd_q[s-1];
      end
    end
  end

  logic signed [AN-1:0] ps, pitch_d;
  assign ps = $signed(p_ang);

  always_comb begin
    if (ps > qte_pkg::PITCH_MAX) begin
      pitch_d = qte_pkg::PITCH_MAX;
    end else if (ps < qte_pkg::PITCH_MIN) begin
      pitch_d = qte_pkg::PITCH_MIN;
    end else begin
      pitch_d = ps;
    end
  end

  logic                 done_q;
  logic signed [AN-1:0] heading_q, pitch_q, roll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= p_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    heading_q <= $signed(hd_q[ND-1]);
    pitch_q   <= pitch_d;
    roll_q    <= $signed(rd_q[ND-1]);
  end

  logic unused_valid;
  assign unused_valid = h_valid ^ r_valid;

  assign done_o          = done_q;
  assign heading_angle_o = heading_q;
  assign pitch_angle_o   = pitch_q;
  assign roll_angle_o    = roll_q;

endmodule

// File: design/qte_terms.sv
// rotation matrix terms from the quaternion, clamp and radicand for the arcsine
module qte_terms (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic signed [qte_pkg::DATA_WIDTH-1:0] w_i,
  input  logic signed [qte_pkg::DATA_WIDTH-1:0] x_i,
  input  logic signed [qte_pkg::DATA_WIDTH-1:0] y_i,
  input  logic signed [qte_pkg::DATA_WIDTH-1:0] z_i,
  output qte_pkg::qte_terms_t                   terms_o
);

  localparam int TW = qte_pkg::TW;
  localparam int EW = qte_pkg::EW;
  localparam int SQ_W = qte_pkg::SQ_W;
  localparam logic signed [TW-1:0] ONE = TW'(1) <<< qte_pkg::TERM_FRAC;
  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * qte_pkg::TERM_FRAC);

  // stage 1: products
  logic v1_q;
  logic signed [TW-1:0] xz_q, wy_q, xx_q, yy_q, yz_q, wx_q, xy_q, wz_q, zz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    xz_q <= qte_pkg::scale_prod(x_i * z_i);
    wy_q <= qte_pkg::scale_prod(w_i * y_i);
    xx_q <= qte_pkg::scale_prod(x_i * x_i);
    yy_q <= qte_pkg::scale_prod(y_i * y_i);
    yz_q <= qte_pkg::scale_prod(y_i * z_i);
    wx_q <= qte_pkg::scale_prod(w_i * x_i);
    xy_q <= qte_pkg::scale_prod(x_i * y_i);
    wz_q <= qte_pkg::scale_prod(w_i * z_i);
    zz_q <= qte_pkg::scale_prod(z_i * z_i);
  end

  // stage 2: terms and clamp
  logic signed [TW-1:0] e20_d, e22_d, e21_d, e01_d, e11_d;
  logic signed [EW-1:0] e21c_d;

  always_comb begin
    e20_d = (xz_q - wy_q) <<< 1;
    e22_d = ONE - ((xx_q + yy_q) <<< 1);
    e21_d = (yz_q + wx_q) <<< 1;
    e01_d = (xy_q - wz_q) <<< 1;
    e11_d = ONE - ((xx_q + zz_q) <<< 1);
    if (e21_d > ONE) begin
      e21c_d = EW'(ONE);
    end else if (e21_d < -ONE) begin
      e21c_d = EW'(-ONE);
    end else begin
      e21c_d = EW'(e21_d);
    end
  end

  logic v2_q;
  logic signed [TW-1:0] hy2_q, hx2_q, ry2_q, rx2_q;
  logic signed [EW-1:0] e21c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hy2_q   <= -e20_d;
    hx2_q   <= e22_d;
    ry2_q   <= -e01_d;
    rx2_q   <= e11_d;
    e21c2_q <= e21c_d;
  end

  // stage 3: radicand one minus square
  logic signed [2*EW-1:0] sq_d;
  assign sq_d = e21c2_q * e21c2_q;

  logic                 v3_q;
  logic signed [TW-1:0] hy3_q, hx3_q, ry3_q, rx3_q;
  logic signed [EW-1:0] e21c3_q;
  logic [SQ_W-1:0]      rad3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hy3_q   <= hy2_q;
    hx3_q   <= hx2_q;
    ry3_q   <= ry2_q;
    rx3_q   <= rx2_q;
    e21c3_q <= e21c2_q;
    rad3_q  <= ONE_SQ - SQ_W'(sq_d);
  end

  assign terms_o = '{valid: v3_q, hy: hy3_q, hx: hx3_q, ry: ry3_q, rx: rx3_q,
                     e21c: e21c3_q, rad: rad3_q};

endmodule

// File: design/qte_isqrt.sv
// pipelined floor square root, one result bit per stage, with a carried tag
module qte_isqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [qte_pkg::SQ_W-1:0]          rad_i,
  input  logic signed [qte_pkg::EW-1:0]     tag_i,
  output logic                              valid_o,
  output logic [qte_pkg::ROOT_W-1:0]        root_o,
  output logic signed [qte_pkg::EW-1:0]     tag_o
);

  localparam int NS = qte_pkg::ISQ_STAGES;
  localparam int RW = qte_pkg::SQ_W + 1;

  logic                       vld_q  [NS];
  logic [RW-1:0]              n_q    [NS];
  logic [RW-1:0]              root_q [NS];
  logic signed [qte_pkg::EW-1:0] tag_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NS - 1 - s));
    logic                          v_in;
    logic [RW-1:0]                 n_in, r_in, trial, n_d, r_d;
    logic signed [qte_pkg::EW-1:0] t_in;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign n_in = RW'(rad_i);
      assign r_in = '0;
      assign t_in = tag_i;
    end else begin : g_next
      assign v_in = vld_q[s-1];
      assign n_in = n_q[s-1];
      assign r_in = root_q[s-1];
      assign t_in = tag_q[s-1];
    end

    always_comb begin
      trial = r_in + BIT;
      if (n_in >= trial) begin
        n_d = n_in - trial;
        r_d = (r_in >> 1) + BIT;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[s]    <= n_d;
      root_q[s] <= r_d;
      tag_q[s]  <= t_in;
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1][qte_pkg::ROOT_W-1:0];
  assign tag_o   = tag_q[NS-1];

endmodule

// File: design/qte_cordic.sv
// pipelined vectoring cordic giving a rounded 16-bit atan2 angle
module qte_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [qte_pkg::TW-1:0]     y_i,
  input  logic signed [qte_pkg::TW-1:0]     x_i,
  output logic                              valid_o,
  output logic [qte_pkg::ANGLE_W-1:0]       angle_o
);

  localparam int NS = qte_pkg::CORDIC_STAGES;
  localparam int CW = qte_pkg::CW;
  localparam int AW = qte_pkg::AW;

  logic                 vld_q  [NS+1];
  logic                 zero_q [NS+1];
  logic signed [CW-1:0] x_q    [NS+1];
  logic signed [CW-1:0] y_q    [NS+1];
  logic [AW-1:0]        ang_q  [NS+1];

  // quadrant fold
  logic signed [CW-1:0] xe, ye, x0_d, y0_d;
  logic [AW-1:0]        a0_d;

  always_comb begin
    xe   = CW'(x_i);
    ye   = CW'(y_i);
    x0_d = xe;
    y0_d = ye;
    a0_d = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0_d = ye;
        y0_d = -xe;
        a0_d = qte_pkg::ANG_QUARTER;
      end else begin
        x0_d = -ye;
        y0_d = xe;
        a0_d = qte_pkg::ANG_NQUARTER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    x_q[0]    <= x0_d;
    y_q[0]    <= y0_d;
    ang_q[0]  <= a0_d;
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      if (y_q[i] >= 0) begin
        x_q[i+1]   <= x_q[i] + dx;
        y_q[i+1]   <= y_q[i] - dy;
        ang_q[i+1] <= ang_q[i] + qte_pkg::ATAN_TABLE[i];
      end else begin
        x_q[i+1]   <= x_q[i] - dx;
        y_q[i+1]   <= y_q[i] + dy;
        ang_q[i+1] <= ang_q[i] - qte_pkg::ATAN_TABLE[i];
      end
    end
  end

  logic [AW-1:0] rnd;
  assign rnd     = ang_q[NS] + qte_pkg::ANG_ROUND;
  assign valid_o = vld_q[NS];
  assign angle_o = zero_q[NS] ? '0 : rnd[AW-1 -: qte_pkg::ANGLE_W];

endmodule
